@@ rtl/tcgr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcgr_pkg
// Types and fixed constants shared by the text console glyph renderer.
// ----------------------------------------------------------------------------
package tcgr_pkg;

  // Glyph store: a fixed byte store addressed modulo its size.
  localparam int STORE_BYTES     = 32768;
  localparam int STORE_ADDR_BITS = $clog2(STORE_BYTES);

  // Glyph dimension limits applied to the configured sizes.
  localparam int MAX_GLYPH_WIDTH  = 32;
  localparam int MAX_GLYPH_HEIGHT = 32;

  // Queue sizes.
  localparam int CMDQ_DEPTH    = 4;
  localparam int CMDQ_PTR_BITS = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_BITS = $clog2(CMDQ_DEPTH + 1);
  localparam int RESQ_DEPTH    = 4;
  localparam int RESQ_PTR_BITS = $clog2(RESQ_DEPTH);
  localparam int RESQ_CNT_BITS = $clog2(RESQ_DEPTH + 1);

  // Configuration port.
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 13;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SCREEN_WIDTH     = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SCREEN_HEIGHT    = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_GLYPH_WIDTH      = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_GLYPH_HEIGHT     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_GLYPH_SIZE_BYTES = 3'd4;

  // Input operations and result kinds.
  localparam logic OP_CONSOLE    = 1'b0;
  localparam logic OP_FONT_WRITE = 1'b1;
  localparam logic KIND_ROW      = 1'b0;
  localparam logic KIND_CLEAR    = 1'b1;

  // Console control characters.
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_NEWLINE  = 8'h0A;
  localparam logic [7:0] CH_RETURN   = 8'h0D;
  localparam logic [7:0] CH_ESC_BG   = 8'hFE;
  localparam logic [7:0] CH_ESC_FG   = 8'hFF;

  localparam logic [31:0] FG_RESET = 32'h0000_FF00;

  typedef enum logic [2:0] {
    CMD_FONT_WR = 3'd0,
    CMD_SET_FG  = 3'd1,
    CMD_SET_BG  = 3'd2,
    CMD_NEWLINE = 3'd3,
    CMD_TAB     = 3'd4,
    CMD_RETURN  = 3'd5,
    CMD_CHECK   = 3'd6,
    CMD_GLYPH   = 3'd7
  } cmd_code_t;

  typedef struct packed {
    cmd_code_t                  code;
    logic [STORE_ADDR_BITS-1:0] addr;
    logic [31:0]                data;
  } cmd_t;

  typedef struct packed {
    logic        operation;
    logic [7:0]  data_byte;
    logic [14:0] font_address;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [31:0] row_bits;
    logic [31:0] fg_color;
    logic [31:0] bg_color;
    logic        last;
  } res_item_t;

  // Configuration as seen by the back end, sizes already limited.
  typedef struct packed {
    logic [12:0] screen_width;
    logic [12:0] screen_height;
    logic [5:0]  glyph_width;
    logic [5:0]  glyph_height;
    logic [7:0]  glyph_size_bytes;
    logic [2:0]  bytes_per_row;
  } cfg_t;

endpackage

@@ rtl/text_console_glyph_renderer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_glyph_renderer
// Console byte stream to glyph row drawing commands, with an internal font store.
// ----------------------------------------------------------------------------
// Usage: items enter through in_push/in_full, results leave through
// out_empty/out_pop, both behaving as queues. A font write stores one byte
// and yields nothing. A console byte yields an optional clear-screen result
// followed by one result per glyph row for printable bytes; last marks the
// final result of each byte. Configuration is written through cfg_we,
// cfg_index and cfg_data while the block is idle.
// The back end takes one command at a time and walks each console byte
// through its wrap, clear and apply steps; a printable byte then reads its
// rows through the single byte-wide read port of the font store, a byte at
// a time, pausing while the result queue has no room; font writes and
// colour loads are done in the idle state.
// A four-entry command queue lets input beats arrive while a glyph is drawn.
// Reset: synchronous; the cursor homes, colours go to green on black, and
// the font store is not cleared, so it must be loaded before use.
// If the receiver stops popping, the four-entry result queue fills, row
// reads pause, and in_full rises once the command queue fills too.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer #(
  parameter int COORD_BITS = 12
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_push,
  input  tcgr_pkg::in_item_t                     in_item,
  output logic                                   in_full,
  output logic                                   out_empty,
  input  logic                                   out_pop,
  output tcgr_pkg::res_item_t                    out_item,
  input  logic                                   cfg_we,
  input  logic [tcgr_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [tcgr_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
  import tcgr_pkg::*;

  logic [12:0] screen_width_r, screen_height_r;
  logic [5:0]  glyph_width_r, glyph_height_r;
  logic [7:0]  glyph_size_bytes_r;
  logic [5:0]  gw_eff, gh_eff;
  cfg_t        cfg;

  logic      cq_full, cq_push, cq_pop, cq_empty;
  cmd_t      cq_item, cq_head;
  logic      res_push;
  res_item_t res_item;
  logic [RESQ_CNT_BITS-1:0] res_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r     <= 13'd1024;
      screen_height_r    <= 13'd768;
      glyph_width_r      <= 6'd8;
      glyph_height_r     <= 6'd16;
      glyph_size_bytes_r <= 8'd16;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCREEN_WIDTH:     screen_width_r     <= cfg_data[12:0];
        CFG_SCREEN_HEIGHT:    screen_height_r    <= cfg_data[12:0];
        CFG_GLYPH_WIDTH:      glyph_width_r      <= cfg_data[5:0];
        CFG_GLYPH_HEIGHT:     glyph_height_r     <= cfg_data[5:0];
        CFG_GLYPH_SIZE_BYTES: glyph_size_bytes_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign gw_eff = (glyph_width_r > 6'(MAX_GLYPH_WIDTH)) ? 6'(MAX_GLYPH_WIDTH) : glyph_width_r;
  assign gh_eff = (glyph_height_r > 6'(MAX_GLYPH_HEIGHT)) ? 6'(MAX_GLYPH_HEIGHT)
                                                         : glyph_height_r;

  assign cfg.screen_width     = screen_width_r;
  assign cfg.screen_height    = screen_height_r;
  assign cfg.glyph_width      = gw_eff;
  assign cfg.glyph_height     = gh_eff;
  assign cfg.glyph_size_bytes = glyph_size_bytes_r;
  assign cfg.bytes_per_row    = 3'((7'(gw_eff) + 7'd7) >> 3);

  tcgr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_item (in_item),
    .in_full (in_full),
    .cq_full (cq_full),
    .cq_push (cq_push),
    .cq_item (cq_item)
  );

  tcgr_cmd_queue u_cmd_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cq_push),
    .push_item (cq_item),
    .full      (cq_full),
    .pop       (cq_pop),
    .head      (cq_head),
    .empty     (cq_empty)
  );

  tcgr_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cq_empty  (cq_empty),
    .cq_head   (cq_head),
    .cq_pop    (cq_pop),
    .res_count (res_count),
    .res_push  (res_push),
    .res_item  (res_item)
  );

  tcgr_res_queue u_res_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_item (res_item),
    .count     (res_count),
    .pop       (out_pop),
    .head      (out_item),
    .empty     (out_empty)
  );

endmodule

@@ rtl/tcgr_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcgr_front
// Accepts input beats and turns each into a command for the back end, but
// for colour escape payload bytes, which are collected into one command.
// ----------------------------------------------------------------------------
module tcgr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  tcgr_pkg::in_item_t in_item,
  output logic              in_full,
  input  logic              cq_full,
  output logic              cq_push,
  output tcgr_pkg::cmd_t    cq_item
);
  import tcgr_pkg::*;

  typedef enum logic [1:0] {
    ESC_NONE = 2'b00,
    ESC_FG   = 2'b01,
    ESC_BG   = 2'b10
  } esc_tgt_t;

  esc_tgt_t    esc_tgt_r, esc_tgt_nxt;
  logic [1:0]  esc_cnt_r, esc_cnt_nxt;
  logic [31:0] esc_col_r, esc_col_nxt;
  logic [31:0] collected;
  logic        accept;

  assign in_full   = cq_full;
  assign accept    = in_push && !cq_full;
  assign collected = esc_col_r | ({24'd0, in_item.data_byte} << {esc_cnt_r, 3'b000});

  always_comb begin
    esc_tgt_nxt  = esc_tgt_r;
    esc_cnt_nxt  = esc_cnt_r;
    esc_col_nxt  = esc_col_r;
    cq_push      = 1'b0;
    cq_item.code = CMD_CHECK;
    cq_item.addr = in_item.font_address[STORE_ADDR_BITS-1:0];
    cq_item.data = {24'd0, in_item.data_byte};
    if (accept) begin
      if (in_item.operation == OP_FONT_WRITE) begin
        cq_push      = 1'b1;
        cq_item.code = CMD_FONT_WR;
      end else if (esc_tgt_r != ESC_NONE) begin
        // Payload beat: the colour is only handed on after the fourth byte.
        if (esc_cnt_r == 2'd3) begin
          cq_push      = 1'b1;
          cq_item.code = (esc_tgt_r == ESC_FG) ? CMD_SET_FG : CMD_SET_BG;
          cq_item.data = collected;
          esc_tgt_nxt  = ESC_NONE;
          esc_cnt_nxt  = 2'd0;
          esc_col_nxt  = 32'd0;
        end else begin
          esc_cnt_nxt = esc_cnt_r + 2'd1;
          esc_col_nxt = collected;
        end
      end else begin
        cq_push = 1'b1;
        case (in_item.data_byte)
          CH_NEWLINE: cq_item.code = CMD_NEWLINE;
          CH_TAB:     cq_item.code = CMD_TAB;
          CH_RETURN:  cq_item.code = CMD_RETURN;
          CH_ESC_FG, CH_ESC_BG: begin
            // The escape byte itself still runs the wrap and clear checks.
            cq_item.code = CMD_CHECK;
            esc_tgt_nxt  = (in_item.data_byte == CH_ESC_FG) ? ESC_FG : ESC_BG;
            esc_cnt_nxt  = 2'd0;
            esc_col_nxt  = 32'd0;
          end
          default:    cq_item.code = CMD_GLYPH;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_tgt_r <= ESC_NONE;
      esc_cnt_r <= 2'd0;
      esc_col_r <= 32'd0;
    end else begin
      esc_tgt_r <= esc_tgt_nxt;
      esc_cnt_r <= esc_cnt_nxt;
      esc_col_r <= esc_col_nxt;
    end
  end

endmodule

@@ rtl/tcgr_cmd_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcgr_cmd_queue
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module tcgr_cmd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tcgr_pkg::cmd_t push_item,
  output logic           full,
  input  logic           pop,
  output tcgr_pkg::cmd_t head,
  output logic           empty
);
  import tcgr_pkg::*;

  cmd_t                     slots [CMDQ_DEPTH];
  logic [CMDQ_PTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [CMDQ_CNT_BITS-1:0] count_r;
  logic                     do_push, do_pop;

  assign full    = (count_r == CMDQ_CNT_BITS'(CMDQ_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ rtl/tcgr_res_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcgr_res_queue
// Result queue that decouples the back end from the receiver.
// ----------------------------------------------------------------------------
module tcgr_res_queue (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   push,
  input  tcgr_pkg::res_item_t                    push_item,
  output logic [tcgr_pkg::RESQ_CNT_BITS-1:0]     count,
  input  logic                                   pop,
  output tcgr_pkg::res_item_t                    head,
  output logic                                   empty
);
  import tcgr_pkg::*;

  res_item_t                slots [RESQ_DEPTH];
  logic [RESQ_PTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [RESQ_CNT_BITS-1:0] count_r;
  logic                     full, do_push, do_pop;

  assign full    = (count_r == RESQ_CNT_BITS'(RESQ_DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ rtl/tcgr_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcgr_back
// Executes commands: font store writes, colour loads, cursor moves, screen
// clears and glyph row reads from the font store.
// ----------------------------------------------------------------------------
module tcgr_back #(
  parameter int COORD_BITS = 12
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tcgr_pkg::cfg_t                     cfg,
  input  logic                               cq_empty,
  input  tcgr_pkg::cmd_t                     cq_head,
  output logic                               cq_pop,
  input  logic [tcgr_pkg::RESQ_CNT_BITS-1:0] res_count,
  output logic                               res_push,
  output tcgr_pkg::res_item_t                res_item
);
  import tcgr_pkg::*;

  localparam int WPROD_BITS = COORD_BITS + 7;
  localparam int HPROD_BITS = COORD_BITS + 6;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_WRAP  = 5'b00010,
    S_CLEAR = 5'b00100,
    S_APPLY = 5'b01000,
    S_ROWS  = 5'b10000
  } bk_state_t;

  logic [7:0] glyph_mem [STORE_BYTES];

  bk_state_t             state_r, state_nxt;
  cmd_code_t             code_r, code_nxt;
  logic [7:0]            byte_r, byte_nxt;
  logic [COORD_BITS-1:0] col_r, col_nxt;
  logic [COORD_BITS-1:0] line_r, line_nxt;
  logic [31:0]           fg_r, fg_nxt;
  logic [31:0]           bg_r, bg_nxt;
  logic [11:0]           px_r, px_nxt;
  logic [11:0]           py_r, py_nxt;
  logic [15:0]           base_r, base_nxt;
  logic [6:0]            roff_r, roff_nxt;
  logic [4:0]            y_r, y_nxt;
  logic [1:0]            b_r, b_nxt;

  // Read pipeline: one store byte per beat, data registered.
  logic        rd_v_r, rd_null_r, rd_rowend_r, rd_last_r;
  logic [1:0]  rd_b_r;
  logic [11:0] rd_py_r;
  logic [7:0]  mem_q_r;
  logic [31:0] acc_r;

  logic [COORD_BITS:0]          col_inc;
  logic [WPROD_BITS-1:0]        wrap_prod;
  logic [HPROD_BITS-1:0]        line_prod, col_prod;
  logic [15:0]                  base_prod;
  logic                         wrap_hit, clear_hit;
  logic [STORE_ADDR_BITS-1:0]   rd_addr;
  logic                         row_done, y_last, rows_pending, res_room;
  logic                         issue, mem_we, clr_push, row_push;
  logic [7:0]                   mem_byte;
  logic [31:0]                  assembled;

  assign col_inc   = {1'b0, col_r} + 1'b1;
  assign wrap_prod = WPROD_BITS'(col_inc) * WPROD_BITS'(cfg.glyph_width);
  assign line_prod = HPROD_BITS'(line_r) * HPROD_BITS'(cfg.glyph_height);
  assign col_prod  = HPROD_BITS'(col_r) * HPROD_BITS'(cfg.glyph_width);
  assign base_prod = 16'(byte_r) * 16'(cfg.glyph_size_bytes);
  assign wrap_hit  = wrap_prod >= WPROD_BITS'(cfg.screen_width);
  assign clear_hit = line_prod >= HPROD_BITS'(cfg.screen_height);
  assign rd_addr   = STORE_ADDR_BITS'(base_r + 16'(roff_r) + 16'(b_r));
  assign row_done  = (3'(b_r) + 3'd1) >= cfg.bytes_per_row;
  assign y_last    = (6'(y_r) + 6'd1) == cfg.glyph_height;

  // A row result may still be on its way into the result queue.
  assign rows_pending = rd_v_r && rd_rowend_r;
  assign res_room     = (res_count + RESQ_CNT_BITS'(rows_pending))
                        < RESQ_CNT_BITS'(RESQ_DEPTH);

  assign cq_pop = (state_r == S_IDLE) && !cq_empty;
  assign mem_we = cq_pop && (cq_head.code == CMD_FONT_WR);
  assign issue  = (state_r == S_ROWS) && res_room;

  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    byte_nxt  = byte_r;
    col_nxt   = col_r;
    line_nxt  = line_r;
    fg_nxt    = fg_r;
    bg_nxt    = bg_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    base_nxt  = base_r;
    roff_nxt  = roff_r;
    y_nxt     = y_r;
    b_nxt     = b_r;
    clr_push  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (cq_pop) begin
          case (cq_head.code)
            CMD_FONT_WR: ;
            CMD_SET_FG:  fg_nxt = cq_head.data;
            CMD_SET_BG:  bg_nxt = cq_head.data;
            default: begin
              code_nxt  = cq_head.code;
              byte_nxt  = cq_head.data[7:0];
              state_nxt = S_WRAP;
            end
          endcase
        end
      end
      S_WRAP: begin
        if (wrap_hit) begin
          col_nxt  = '0;
          line_nxt = line_r + 1'b1;
        end
        state_nxt = S_CLEAR;
      end
      S_CLEAR: begin
        if (!clear_hit) begin
          state_nxt = S_APPLY;
        end else if (res_room && !rd_v_r) begin
          clr_push  = 1'b1;
          col_nxt   = '0;
          line_nxt  = '0;
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        state_nxt = S_IDLE;
        case (code_r)
          CMD_NEWLINE: begin
            col_nxt  = '0;
            line_nxt = line_r + 1'b1;
          end
          CMD_TAB:     col_nxt = {col_r[COORD_BITS-1:2], 2'b00} + COORD_BITS'(4);
          CMD_RETURN:  col_nxt = '0;
          CMD_GLYPH: begin
            px_nxt   = col_prod[11:0];
            py_nxt   = line_prod[11:0];
            base_nxt = base_prod;
            roff_nxt = '0;
            y_nxt    = '0;
            b_nxt    = '0;
            col_nxt  = col_r + 1'b1;
            if (cfg.glyph_height != 6'd0) begin
              state_nxt = S_ROWS;
            end
          end
          default: ;
        endcase
      end
      S_ROWS: begin
        if (issue) begin
          if (row_done) begin
            b_nxt    = '0;
            y_nxt    = y_r + 1'b1;
            roff_nxt = roff_r + 7'(cfg.bytes_per_row);
            py_nxt   = py_r + 1'b1;
            if (y_last) begin
              state_nxt = S_IDLE;
            end
          end else begin
            b_nxt = b_r + 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      glyph_mem[cq_head.addr] <= cq_head.data[7:0];
    end
    if (issue && (cfg.bytes_per_row != 3'd0)) begin
      mem_q_r <= glyph_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      col_r   <= '0;
      line_r  <= '0;
      fg_r    <= FG_RESET;
      bg_r    <= 32'd0;
      rd_v_r  <= 1'b0;
      acc_r   <= 32'd0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      line_r  <= line_nxt;
      fg_r    <= fg_nxt;
      bg_r    <= bg_nxt;
      rd_v_r  <= issue;
      if (rd_v_r) begin
        acc_r <= rd_rowend_r ? 32'd0 : assembled;
      end
    end
  end

  always_ff @(posedge clk) begin
    code_r      <= code_nxt;
    byte_r      <= byte_nxt;
    px_r        <= px_nxt;
    py_r        <= py_nxt;
    base_r      <= base_nxt;
    roff_r      <= roff_nxt;
    y_r         <= y_nxt;
    b_r         <= b_nxt;
    rd_null_r   <= (cfg.bytes_per_row == 3'd0);
    rd_b_r      <= b_r;
    rd_rowend_r <= row_done;
    rd_last_r   <= row_done && y_last;
    rd_py_r     <= py_r;
  end

  // With zero bytes per row a beat still flows, carrying an empty row.
  assign mem_byte  = rd_null_r ? 8'd0 : mem_q_r;
  assign assembled = acc_r | ({24'd0, mem_byte} << {rd_b_r, 3'b000});
  assign row_push  = rd_v_r && rd_rowend_r;
  assign res_push  = row_push || clr_push;

  always_comb begin
    if (clr_push) begin
      res_item.kind     = KIND_CLEAR;
      res_item.pixel_x  = 12'd0;
      res_item.pixel_y  = 12'd0;
      res_item.row_bits = 32'd0;
      res_item.fg_color = 32'd0;
      res_item.bg_color = 32'd0;
      res_item.last     = !((code_r == CMD_GLYPH) && (cfg.glyph_height != 6'd0));
    end else begin
      res_item.kind     = KIND_ROW;
      res_item.pixel_x  = px_r;
      res_item.pixel_y  = rd_py_r;
      res_item.row_bits = assembled;
      res_item.fg_color = fg_r;
      res_item.bg_color = bg_r;
      res_item.last     = rd_last_r;
    end
  end

`ifndef ASSERT_OFF
  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (res_count < RESQ_CNT_BITS'(RESQ_DEPTH)))
    else $error("result pushed into a full result queue");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cq_pop |-> (state_r == S_IDLE))
    else $error("command taken while the back end is busy");

  a_tab_align: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_APPLY) && (code_r == CMD_TAB)) |=> (col_r[1:0] == 2'b00))
    else $error("tab left the cursor off a multiple of four");

  a_one_push: assert property (@(posedge clk) disable iff (!rst_n)
    clr_push |-> !row_push)
    else $error("clear and glyph row pushed in the same cycle");
`endif

endmodule

@@ sim/tb_text_console_glyph_renderer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_glyph_renderer
// Self-checking bench for the text console glyph renderer.
// A directed table exercises control characters, colour escapes, wrapping
// and screen clears, then mostly randomised phases run across a range of
// screen and font geometries, including zero and oversize settings and
// cursor counter overflow. Result beats are checked against an in-bench
// prediction of the cursor, colour, escape and font store behaviour or a fixed table entry.
// ----------------------------------------------------------------------------
module tb_text_console_glyph_renderer;
  import tcgr_pkg::*;

  localparam int PREDICTED      = -1;
  localparam int PLAN_ROWS      = 23;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 64;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int REPORT_LIMIT   = 10;

  localparam res_item_t CLEAR_LAST = '{kind: KIND_CLEAR, last: 1'b1, default: '0};

  typedef enum logic [1:0] {
    ESC_IDLE,
    ESC_LOAD_FG,
    ESC_LOAD_BG
  } esc_state_t;

  typedef struct {
    in_item_t  beat;
    int        fixed_count;
    res_item_t fixed_row;
  } plan_row_t;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_push;
  in_item_t                  in_item;
  logic                      in_full;
  logic                      out_empty;
  logic                      out_pop;
  res_item_t                 out_item;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  // Shadow of the block's configuration and state.
  logic [12:0] scr_w, scr_h;
  logic [5:0]  glyph_w, glyph_h;
  logic [7:0]  glyph_bytes;
  logic [11:0] cur_col, cur_line;
  logic [31:0] fg_colour, bg_colour;
  esc_state_t  esc_state;
  int          esc_count;
  logic [31:0] esc_value;
  logic [7:0]  font_shadow [STORE_BYTES];
  bit          font_known  [STORE_BYTES];

  res_item_t awaited_cmds[$];
  int        mismatches = 0;
  bit        tail_mode = 1'b0;
  int        hold_asked = 0;
  int        hold_seen = 0;
  int        stall_left = 0;
  int        run_left = 0;
  int        idle_cycles = 0;

  plan_row_t plan [PLAN_ROWS] = '{
    '{'{OP_FONT_WRITE, 8'hFF, 15'h7FFF}, 0, '0},
    '{'{OP_FONT_WRITE, 8'h00, 15'h0000}, 0, '0},
    '{'{OP_CONSOLE, 8'h41, 15'h0000}, PREDICTED, '0},
    '{'{OP_CONSOLE, 8'h00, 15'h7FFF}, PREDICTED, '0},
    '{'{OP_CONSOLE, 8'h80, 15'h0000}, PREDICTED, '0},
    '{'{OP_CONSOLE, 8'hFD, 15'h0000}, PREDICTED, '0},
    '{'{OP_CONSOLE, CH_TAB, 15'h0000}, PREDICTED, '0},
    '{'{OP_CONSOLE, CH_ESC_FG, 15'h0000}, 0, '0},
    '{'{OP_CONSOLE, CH_NEWLINE, 15'h0000}, 0, '0},
    '{'{OP_CONSOLE, CH_ESC_FG, 15'h0000}, 0, '0},
    '{'{OP_FONT_WRITE, 8'h5A, 15'h1234}, 0, '0},
    '{'{OP_CONSOLE, 8'h00, 15'h0000}, 0, '0},
    '{'{OP_CONSOLE, 8'h80, 15'h0000}, 0, '0},
    '{'{OP_CONSOLE, CH_ESC_BG, 15'h0000}, 0, '0},
    '{'{OP_CONSOLE, 8'h01, 15'h0000}, 0, '0},
    '{'{OP_CONSOLE, 8'h02, 15'h0000}, 0, '0},
    '{'{OP_CONSOLE, 8'h03, 15'h0000}, 0, '0},
    '{'{OP_CONSOLE, 8'h04, 15'h0000}, 0, '0},
    '{'{OP_CONSOLE, 8'h41, 15'h0000}, PREDICTED, '0},
    '{'{OP_CONSOLE, CH_RETURN, 15'h0000}, 0, '0},
    '{'{OP_CONSOLE, CH_NEWLINE, 15'h0000}, 0, '0},
    '{'{OP_CONSOLE, CH_NEWLINE, 15'h0000}, 1, CLEAR_LAST},
    '{'{OP_CONSOLE, 8'h41, 15'h0000}, PREDICTED, '0}
  };

  text_console_glyph_renderer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic bit is_printable(input logic [7:0] ch);
    return !(ch inside {CH_TAB, CH_NEWLINE, CH_RETURN, CH_ESC_FG, CH_ESC_BG});
  endfunction

  function automatic int unsigned eff_width();
    return (glyph_w > MAX_GLYPH_WIDTH) ? MAX_GLYPH_WIDTH : glyph_w;
  endfunction

  function automatic int unsigned eff_height();
    return (glyph_h > MAX_GLYPH_HEIGHT) ? MAX_GLYPH_HEIGHT : glyph_h;
  endfunction

  function automatic int unsigned row_bytes();
    return (eff_width() + 7) / 8;
  endfunction

  function automatic int unsigned store_addr(input int unsigned ch, input int unsigned y,
                                             input int unsigned b);
    return (ch * glyph_bytes + y * row_bytes() + b) % STORE_BYTES;
  endfunction

  // Works out the commands one accepted beat gives rise to, and moves the
  // shadow state on as the block would.
  task automatic render_beat(input in_item_t beat, ref res_item_t cmds[$]);
    int unsigned gw, gh, px, py, bits, a, t;
    res_item_t   r;
    cmds.delete();
    gw = eff_width();
    gh = eff_height();
    if (beat.operation == OP_FONT_WRITE) begin
      font_shadow[beat.font_address] = beat.data_byte;
      font_known[beat.font_address]  = 1'b1;
      return;
    end
    // Escape payload bypasses wrapping, clearing and drawing altogether.
    if (esc_state != ESC_IDLE) begin
      esc_value = esc_value | (32'(beat.data_byte) << (8 * esc_count));
      esc_count++;
      if (esc_count >= 4) begin
        if (esc_state == ESC_LOAD_FG) begin
          fg_colour = esc_value;
        end else begin
          bg_colour = esc_value;
        end
        esc_state = ESC_IDLE;
        esc_count = 0;
        esc_value = '0;
      end
      return;
    end
    t = cur_col;
    if ((t + 1) * gw >= scr_w) begin
      cur_col  = '0;
      cur_line = cur_line + 12'd1;
    end
    t = cur_line;
    if (t * gh >= scr_h) begin
      cmds.push_back(CLEAR_LAST);
      cmds[0].last = 1'b0;
      cur_line = '0;
      cur_col  = '0;
    end
    case (beat.data_byte)
      CH_NEWLINE: begin
        cur_col  = '0;
        cur_line = cur_line + 12'd1;
      end
      CH_TAB: cur_col = cur_col + 12'd4 - (cur_col % 12'd4);
      CH_RETURN: cur_col = '0;
      CH_ESC_FG, CH_ESC_BG: begin
        esc_state = (beat.data_byte == CH_ESC_FG) ? ESC_LOAD_FG : ESC_LOAD_BG;
        esc_count = 0;
        esc_value = '0;
      end
      default: begin
        t  = cur_col;
        px = t * gw;
        t  = cur_line;
        py = t * gh;
        for (int y = 0; y < gh; y++) begin
          bits = 0;
          for (int b = 0; b < row_bytes(); b++) begin
            a    = store_addr(beat.data_byte, y, b);
            bits = bits | (32'(font_shadow[a]) << (8 * b));
          end
          t = py + y;
          r.kind     = KIND_ROW;
          r.pixel_x  = px[11:0];
          r.pixel_y  = t[11:0];
          r.row_bits = bits;
          r.fg_color = fg_colour;
          r.bg_color = bg_colour;
          r.last     = 1'b0;
          cmds.push_back(r);
        end
        cur_col = cur_col + 12'd1;
      end
    endcase
    if (cmds.size() > 0) cmds[cmds.size()-1].last = 1'b1;
  endtask

  // Offers one beat, waits for it to be taken and records what it should
  // produce. Entered and left at a falling edge.
  task automatic send_beat(input in_item_t beat, input int fixed_count,
                           input res_item_t fixed_row);
    res_item_t cmds[$];
    if (!tail_mode && $urandom_range(0, 3) == 0) begin
      in_push = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_item = beat;
    in_push = 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    render_beat(beat, cmds);
    if (fixed_count == PREDICTED) begin
      foreach (cmds[i]) awaited_cmds.push_back(cmds[i]);
    end else begin
      repeat (fixed_count) awaited_cmds.push_back(fixed_row);
    end
    @(negedge clk);
  endtask

  task automatic font_write(input logic [14:0] addr, input logic [7:0] data);
    in_item_t beat;
    beat.operation    = OP_FONT_WRITE;
    beat.data_byte    = data;
    beat.font_address = addr;
    send_beat(beat, PREDICTED, '0);
  endtask

  // Fills every font byte the glyph will read under the present geometry, so
  // that no draw ever touches an entry that was never written.
  task automatic load_glyph(input logic [7:0] ch);
    int unsigned a;
    for (int y = 0; y < eff_height(); y++) begin
      for (int b = 0; b < row_bytes(); b++) begin
        a = store_addr(ch, y, b);
        if (!font_known[a]) font_write(a[14:0], 8'($urandom));
      end
    end
  endtask

  task automatic console(input logic [7:0] ch);
    in_item_t beat;
    if (esc_state == ESC_IDLE && is_printable(ch)) load_glyph(ch);
    beat.operation    = OP_CONSOLE;
    beat.data_byte    = ch;
    beat.font_address = 15'($urandom_range(0, STORE_BYTES - 1));
    send_beat(beat, PREDICTED, '0);
  endtask

  task automatic random_beats(input int count);
    logic [7:0] glyph_set [4];
    logic [7:0] ch;
    int         pick;
    foreach (glyph_set[i]) begin
      do ch = 8'($urandom_range(0, 255)); while (!is_printable(ch));
      glyph_set[i] = ch;
    end
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        console(glyph_set[$urandom_range(0, 3)]);
      end else if (pick < 65) begin
        case ($urandom_range(0, 2))
          0: console(CH_TAB);
          1: console(CH_NEWLINE);
          default: console(CH_RETURN);
        endcase
      end else if (pick < 73) begin
        // Colour escape with random payload, now and then split by a font write.
        console($urandom_range(0, 1) ? CH_ESC_FG : CH_ESC_BG);
        for (int k = 0; k < 4; k++) begin
          if ($urandom_range(0, 5) == 0) begin
            font_write(15'($urandom_range(0, STORE_BYTES - 1)), 8'($urandom));
          end
          console(8'($urandom_range(0, 255)));
        end
      end else if (pick < 85) begin
        font_write(15'($urandom_range(0, STORE_BYTES - 1)), 8'($urandom));
      end else begin
        console(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic set_geometry(input int unsigned sw, input int unsigned sh,
                              input int unsigned gw, input int unsigned gh,
                              input int unsigned gsb);
    cfg_we    = 1'b1;
    cfg_index = CFG_SCREEN_WIDTH;
    cfg_data  = sw[12:0];
    @(negedge clk);
    cfg_index = CFG_SCREEN_HEIGHT;
    cfg_data  = sh[12:0];
    @(negedge clk);
    cfg_index = CFG_GLYPH_WIDTH;
    cfg_data  = 13'(gw[5:0]);
    @(negedge clk);
    cfg_index = CFG_GLYPH_HEIGHT;
    cfg_data  = 13'(gh[5:0]);
    @(negedge clk);
    cfg_index = CFG_GLYPH_SIZE_BYTES;
    cfg_data  = 13'(gsb[7:0]);
    @(negedge clk);
    cfg_we      = 1'b0;
    scr_w       = sw[12:0];
    scr_h       = sh[12:0];
    glyph_w     = gw[5:0];
    glyph_h     = gh[5:0];
    glyph_bytes = gsb[7:0];
  endtask

  // Waits until every predicted command has been seen, then lets the block
  // finish any trailing work that produces nothing.
  task automatic settle();
    in_push = 1'b0;
    while (awaited_cmds.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(input int unsigned sw, input int unsigned sh,
                           input int unsigned gw, input int unsigned gh,
                           input int unsigned gsb, input int count);
    set_geometry(sw, sh, gw, gh, gsb);
    random_beats(count);
    settle();
  endtask

  task automatic report(input string what, input res_item_t want, input res_item_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("%0t: %s", $realtime, what);
      $display("  expected kind %0d x %0d y %0d bits %h fg %h bg %h last %0d",
               want.kind, want.pixel_x, want.pixel_y, want.row_bits,
               want.fg_color, want.bg_color, want.last);
      $display("  actual   kind %0d x %0d y %0d bits %h fg %h bg %h last %0d",
               got.kind, got.pixel_x, got.pixel_y, got.row_bits,
               got.fg_color, got.bg_color, got.last);
    end
  endtask

  // Result side: bursts of popping and stalling, plus the long hold-off.
  always @(negedge clk) begin
    if (hold_seen != hold_asked) begin
      hold_seen  = hold_asked;
      stall_left = HOLD_CYCLES;
      run_left   = 0;
    end
    if (stall_left > 0) begin
      out_pop = 1'b0;
      stall_left--;
    end else if (tail_mode) begin
      out_pop = 1'b1;
    end else if (run_left > 0) begin
      out_pop = 1'b1;
      run_left--;
    end else if ($urandom_range(0, 2) == 0) begin
      out_pop    = 1'b0;
      stall_left = $urandom_range(0, 14);
    end else begin
      out_pop  = 1'b1;
      run_left = $urandom_range(0, 29);
    end
  end

  always @(posedge clk) begin
    res_item_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (awaited_cmds.size() == 0) begin
        report("result beat with nothing expected", '0, out_item);
      end else begin
        want = awaited_cmds.pop_front();
        if (out_item.kind !== want.kind || out_item.pixel_x !== want.pixel_x ||
            out_item.pixel_y !== want.pixel_y || out_item.row_bits !== want.row_bits ||
            out_item.fg_color !== want.fg_color || out_item.bg_color !== want.bg_color ||
            out_item.last !== want.last) begin
          report("result beat mismatch", want, out_item);
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither side moves a beat.
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_push   = 1'b0;
    in_item   = '0;
    out_pop   = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_SCREEN_WIDTH;
    cfg_data  = '0;
    scr_w       = 13'd1024;
    scr_h       = 13'd768;
    glyph_w     = 6'd8;
    glyph_h     = 6'd16;
    glyph_bytes = 8'd16;
    cur_col   = '0;
    cur_line  = '0;
    fg_colour = FG_RESET;
    bg_colour = '0;
    esc_state = ESC_IDLE;
    esc_count = 0;
    esc_value = '0;
    foreach (font_known[i]) begin
      font_known[i]  = 1'b0;
      font_shadow[i] = '0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Small screen: two columns and four lines, so wraps and clears come early.
    set_geometry(24, 16, 8, 4, 4);
    foreach (plan[i]) begin
      if (plan[i].beat.operation == OP_CONSOLE && esc_state == ESC_IDLE &&
          is_printable(plan[i].beat.data_byte)) begin
        load_glyph(plan[i].beat.data_byte);
      end
      send_beat(plan[i].beat, plan[i].fixed_count, plan[i].fixed_row);
    end
    settle();

    // Reset geometry; the receiver holds off mid-phase so both queues fill.
    set_geometry(1024, 768, 8, 16, 16);
    random_beats(5);
    hold_asked++;
    random_beats(15);
    settle();

    run_phase(4096, 4096, 32, 32, 128, 12);
    run_phase(1, 1, 1, 1, 1, 20);
    // Zero screen, zero glyph height and an oversize glyph width.
    run_phase(0, 0, 63, 0, 255, 15);
    run_phase(200, 100, 12, 40, 37, 20);

    // Column and line counters run past their width and wrap to zero.
    set_geometry(8191, 8191, 1, 1, 1);
    repeat (1023) console(CH_TAB);
    console(8'h58);
    console(CH_TAB);
    console(8'h58);
    repeat (4095) console(CH_NEWLINE);
    console(8'h58);
    console(CH_NEWLINE);
    console(8'h58);
    settle();

    // Wide glyphs far to the right: pixel_x keeps only its low bits.
    set_geometry(8191, 8191, 32, 2, 64);
    repeat (63) console(CH_TAB);
    random_beats(20);
    settle();

    tail_mode = 1'b1;
    run_phase(640, 480, 8, 16, 16, 40);

    mismatches += awaited_cmds.size();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/tcgr_pkg.sv
rtl/tcgr_front.sv
rtl/tcgr_cmd_queue.sv
rtl/tcgr_res_queue.sv
rtl/tcgr_back.sv
rtl/text_console_glyph_renderer.sv
sim/tb_text_console_glyph_renderer.sv
